// ===== src/rbj_pkg.sv =====
package rbj_pkg;

  localparam int RBJ_TIME_W      = 32;
  localparam int RBJ_ATT_W       = 8;
  localparam int RBJ_KIND_W      = 2;
  localparam int RBJ_CNT_W       = 3;
  localparam int RBJ_PCT_W       = 8;
  localparam int RBJ_TABLE_SLOTS = 6;
  localparam int RBJ_MAX_STEPS   = 6;
  localparam int RBJ_SLOT_W      = 3;
  localparam int RBJ_CFG_IDX_W   = 4;
  localparam int RBJ_PROD_W      = 2 * RBJ_TIME_W;
  localparam int RBJ_QUOT_W      = 27;
  localparam int RBJ_RECIP_SHIFT = 37;

  // Hash constants, the golden ratio step and the reciprocal of 100 (shift 37).
  localparam logic [RBJ_TIME_W-1:0] RBJ_MIX_C1 = 32'h7feb352d;
  localparam logic [RBJ_TIME_W-1:0] RBJ_MIX_C2 = 32'h846ca68b;
  localparam logic [RBJ_TIME_W-1:0] RBJ_GOLDEN = 32'h9E3779B9;
  localparam logic [RBJ_TIME_W-1:0] RBJ_RECIP  = 32'h51EB851F;
  localparam logic [RBJ_ATT_W-1:0]  RBJ_ATT_MAX = 8'hFF;

  localparam logic [RBJ_KIND_W-1:0] KIND_FAIL  = 2'd0;
  localparam logic [RBJ_KIND_W-1:0] KIND_POLL  = 2'd1;
  localparam logic [RBJ_KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [RBJ_CFG_IDX_W-1:0] REG_STEP_COUNT  = 4'd0;
  localparam logic [RBJ_CFG_IDX_W-1:0] REG_JITTER_PCT  = 4'd1;
  localparam logic [RBJ_CFG_IDX_W-1:0] REG_STEP_DELAY0 = 4'd2;

  typedef struct packed {
    logic [RBJ_CNT_W-1:0]                        step_count;
    logic [RBJ_PCT_W-1:0]                        spread_pct;
    logic [RBJ_TABLE_SLOTS-1:0][RBJ_TIME_W-1:0]  step_delay;
  } rbj_cfg_t;

  typedef struct packed {
    logic                  start;
    logic [RBJ_TIME_W-1:0] dividend;
    logic [RBJ_TIME_W-1:0] divisor;
  } rbj_mod_req_t;

  typedef struct packed {
    logic                  done;
    logic [RBJ_TIME_W-1:0] rem;
  } rbj_mod_rsp_t;

endpackage

// ===== src/rbj_if.sv =====
interface rbj_in_if;
  import rbj_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [RBJ_KIND_W-1:0] kind;
  logic [RBJ_TIME_W-1:0] now_ms;
  modport source (output valid, kind, now_ms, input ready);
  modport sink   (input valid, kind, now_ms, output ready);
endinterface

interface rbj_out_if;
  import rbj_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  is_ready;
  logic [RBJ_TIME_W-1:0] delay_ms;
  logic [RBJ_ATT_W-1:0]  attempt_count;
  modport source (output valid, is_ready, delay_ms, attempt_count, input ready);
  modport sink   (input valid, is_ready, delay_ms, attempt_count, output ready);
endinterface

interface rbj_cfg_if;
  import rbj_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [RBJ_CFG_IDX_W-1:0] index;
  logic [RBJ_TIME_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/rbj_mul.sv =====
module rbj_mul (
  input  logic                           clk,
  input  logic [rbj_pkg::RBJ_TIME_W-1:0] a,
  input  logic [rbj_pkg::RBJ_TIME_W-1:0] b,
  output logic [rbj_pkg::RBJ_PROD_W-1:0] prod
);
  import rbj_pkg::*;

  logic [RBJ_PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= RBJ_PROD_W'(a) * RBJ_PROD_W'(b);
  end

  assign prod = prod_r;

endmodule

// ===== src/rbj_mod.sv =====
module rbj_mod (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rbj_pkg::rbj_mod_req_t req,
  output rbj_pkg::rbj_mod_rsp_t rsp
);
  import rbj_pkg::*;

  localparam int CNT_W = $clog2(RBJ_TIME_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(RBJ_TIME_W - 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [RBJ_TIME_W-1:0] rem_r;
  logic [RBJ_TIME_W-1:0] dvd_r;
  logic [RBJ_TIME_W-1:0] dsr_r;
  logic [RBJ_TIME_W:0]   rem_sh;
  logic [RBJ_TIME_W:0]   diff;
  logic [RBJ_TIME_W-1:0] rem_nxt;

  // One restoring step: the partial remainder stays below the divisor.
  always_comb begin
    rem_sh  = {rem_r, dvd_r[RBJ_TIME_W-1]};
    diff    = rem_sh - {1'b0, dsr_r};
    rem_nxt = diff[RBJ_TIME_W] ? rem_sh[RBJ_TIME_W-1:0] : diff[RBJ_TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[RBJ_TIME_W-2:0], 1'b0};
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== src/rbj_seq.sv =====
module rbj_seq #(
  parameter int MAX_STEPS = rbj_pkg::RBJ_MAX_STEPS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rbj_pkg::rbj_cfg_t              cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rbj_pkg::RBJ_KIND_W-1:0] in_kind,
  input  logic [rbj_pkg::RBJ_TIME_W-1:0] in_now_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_is_ready,
  output logic [rbj_pkg::RBJ_TIME_W-1:0] out_delay_ms,
  output logic [rbj_pkg::RBJ_ATT_W-1:0]  out_attempt_count
);
  import rbj_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_RECIP  = 9'b000000010,
    ST_SPAN   = 9'b000000100,
    ST_SEED   = 9'b000001000,
    ST_MIX1   = 9'b000010000,
    ST_MIX2   = 9'b000100000,
    ST_MSTART = 9'b001000000,
    ST_MODW   = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [RBJ_TIME_W-1:0] base_r, base_nxt;
  logic [RBJ_TIME_W-1:0] now_r, now_nxt;
  logic [RBJ_TIME_W-1:0] span_r, span_nxt;
  logic [RBJ_TIME_W:0]   up_r, up_nxt;
  logic [RBJ_ATT_W-1:0]  att_r, att_nxt;
  logic [RBJ_TIME_W-1:0] last_r, last_nxt;
  logic [RBJ_TIME_W-1:0] delay_r, delay_nxt;
  logic                  armed_r, armed_nxt;
  logic                  ov_r, ov_nxt;
  logic                  ordy_r, ordy_nxt;
  logic [RBJ_TIME_W-1:0] odelay_r, odelay_nxt;
  logic [RBJ_ATT_W-1:0]  oatt_r, oatt_nxt;

  logic [RBJ_TIME_W-1:0] mul_a, mul_b;
  logic [RBJ_PROD_W-1:0] prod;
  rbj_mod_req_t          mod_req;
  rbj_mod_rsp_t          mod_rsp;

  logic [RBJ_CNT_W-1:0]  cnt_eff;
  logic [RBJ_SLOT_W-1:0] idx;
  logic [RBJ_TIME_W-1:0] p;
  logic [RBJ_TIME_W-1:0] seed;
  logic [RBJ_TIME_W-1:0] elapsed;
  logic                  load_out;
  logic                  accept;

  rbj_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  rbj_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  assign in_ready = (state_r == ST_IDLE) && (!ov_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cnt_eff = (cfg.step_count > RBJ_CNT_W'(MAX_STEPS)) ?
              RBJ_CNT_W'(MAX_STEPS) : cfg.step_count;
    if (att_r < RBJ_ATT_W'(cnt_eff)) begin
      idx = RBJ_SLOT_W'(att_r);
    end else begin
      idx = RBJ_SLOT_W'(cnt_eff - 1'b1);
    end
    p    = prod[RBJ_TIME_W-1:0];
    seed = now_r ^ p;
  end

  always_comb begin
    state_nxt = state_r;
    base_nxt  = base_r;
    now_nxt   = now_r;
    span_nxt  = span_r;
    up_nxt    = up_r;
    att_nxt   = att_r;
    last_nxt  = last_r;
    delay_nxt = delay_r;
    armed_nxt = armed_r;
    ov_nxt    = ov_r;
    ordy_nxt  = ordy_r;
    odelay_nxt = odelay_r;
    oatt_nxt  = oatt_r;
    mul_a     = '0;
    mul_b     = '0;
    mod_req   = '0;
    load_out  = 1'b0;
    elapsed   = '0;

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          case (in_kind)
            KIND_FAIL: begin
              if (cnt_eff != '0) begin
                load_out  = 1'b0;
                base_nxt  = cfg.step_delay[idx];
                now_nxt   = in_now_ms;
                state_nxt = ST_RECIP;
              end
            end
            KIND_CLEAR: begin
              att_nxt   = '0;
              last_nxt  = '0;
              delay_nxt = '0;
              armed_nxt = 1'b0;
            end
            default: begin
            end
          endcase
          elapsed = in_now_ms - last_nxt;
        end
      end
      ST_RECIP: begin
        mul_a     = base_r;
        mul_b     = RBJ_RECIP;
        state_nxt = ST_SPAN;
      end
      ST_SPAN: begin
        // The high product bits hold base / 100.
        mul_a     = RBJ_TIME_W'(prod[RBJ_RECIP_SHIFT +: RBJ_QUOT_W]);
        mul_b     = RBJ_TIME_W'(cfg.spread_pct);
        state_nxt = ST_SEED;
      end
      ST_SEED: begin
        span_nxt = p;
        if (p == '0) begin
          // No jitter: finish with the base delay unchanged.
          up_nxt    = {1'b0, base_r};
          state_nxt = ST_FINISH;
        end else begin
          mul_a     = RBJ_TIME_W'(att_r);
          mul_b     = RBJ_GOLDEN;
          state_nxt = ST_MIX1;
        end
      end
      ST_MIX1: begin
        mul_a     = seed ^ (seed >> 16);
        mul_b     = RBJ_MIX_C1;
        state_nxt = ST_MIX2;
      end
      ST_MIX2: begin
        mul_a     = p ^ (p >> 15);
        mul_b     = RBJ_MIX_C2;
        state_nxt = ST_MSTART;
      end
      ST_MSTART: begin
        mod_req.start    = 1'b1;
        mod_req.dividend = p ^ (p >> 16);
        mod_req.divisor  = {span_r[RBJ_TIME_W-2:0], 1'b1};
        state_nxt        = ST_MODW;
      end
      ST_MODW: begin
        if (mod_rsp.done) begin
          up_nxt    = {1'b0, base_r} + {1'b0, mod_rsp.rem};
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (up_r < {1'b0, span_r}) begin
          delay_nxt = '0;
        end else begin
          delay_nxt = RBJ_TIME_W'(up_r - {1'b0, span_r});
        end
        last_nxt  = now_r;
        armed_nxt = 1'b1;
        if (att_r != RBJ_ATT_MAX) begin
          att_nxt = att_r + 1'b1;
        end
        load_out  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load_out) begin
      ov_nxt     = 1'b1;
      ordy_nxt   = !armed_nxt || (elapsed >= delay_nxt);
      odelay_nxt = armed_nxt ? delay_nxt : '0;
      oatt_nxt   = att_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      att_r   <= '0;
      last_r  <= '0;
      delay_r <= '0;
      armed_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      att_r   <= att_nxt;
      last_r  <= last_nxt;
      delay_r <= delay_nxt;
      armed_r <= armed_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r   <= base_nxt;
    now_r    <= now_nxt;
    span_r   <= span_nxt;
    up_r     <= up_nxt;
    ordy_r   <= ordy_nxt;
    odelay_r <= odelay_nxt;
    oatt_r   <= oatt_nxt;
  end

  assign out_valid         = ov_r;
  assign out_is_ready      = ordy_r;
  assign out_delay_ms      = odelay_r;
  assign out_attempt_count = oatt_r;

endmodule

// ===== src/retry_backoff_jitter_timer_top.sv =====
// Channel   Role    Payload
// in_ch     sink    kind, now_ms
// out_ch    source  is_ready, delay_ms, attempt_count
// cfg_ch    sink    index, data (always ready)
//
// Polls, clears and failures with no steps configured are answered straight from the idle state.
// A failure with jitter passes through the setup states, making five passes
// through the shared multiplier, then the bit-serial modulo unit and a finish state.
// A failure whose jitter span is zero skips the hash and the modulo unit.
// Reset clears the timer state and the configuration registers.
// A new request is taken once the previous result is taken or is taken in
// the same cycle; a stalled output holds the block idle.
module retry_backoff_jitter_timer_top #(
  parameter int MAX_STEPS = rbj_pkg::RBJ_MAX_STEPS
) (
  input logic        clk,
  input logic        rst_n,
  rbj_in_if.sink     in_ch,
  rbj_out_if.source  out_ch,
  rbj_cfg_if.sink    cfg_ch
);
  import rbj_pkg::*;

  rbj_cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_STEP_COUNT) begin
        cfg_r.step_count <= cfg_ch.data[RBJ_CNT_W-1:0];
      end
      if (cfg_ch.index == REG_JITTER_PCT) begin
        cfg_r.spread_pct <= cfg_ch.data[RBJ_PCT_W-1:0];
      end
      for (int i = 0; i < RBJ_TABLE_SLOTS; i++) begin
        if (cfg_ch.index == RBJ_CFG_IDX_W'(REG_STEP_DELAY0 + i)) begin
          cfg_r.step_delay[i] <= cfg_ch.data;
        end
      end
    end
  end

  rbj_seq #(
    .MAX_STEPS (MAX_STEPS)
  ) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_kind           (in_ch.kind),
    .in_now_ms         (in_ch.now_ms),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_is_ready      (out_ch.is_ready),
    .out_delay_ms      (out_ch.delay_ms),
    .out_attempt_count (out_ch.attempt_count)
  );

endmodule

// ===== tb/rbj_status_checker.sv =====
`timescale 1ns / 1ps

module rbj_status_checker (
  input  logic clk,
  input  logic rst_n,
  rbj_in_if    in_mon,
  rbj_out_if   out_mon,
  rbj_cfg_if   cfg_mon,
  output int   errors,
  output int   pending
);
  import rbj_pkg::*;

  typedef struct {
    logic                  is_ready;
    logic [RBJ_TIME_W-1:0] delay_ms;
    logic [RBJ_ATT_W-1:0]  attempt_count;
  } timer_status_t;

  timer_status_t status_q[$];

  // Shadow copy of the registers and of the timer.
  logic [RBJ_CNT_W-1:0]  step_count;
  logic [RBJ_PCT_W-1:0]  jitter_pct;
  logic [RBJ_TIME_W-1:0] step_delay [RBJ_TABLE_SLOTS];
  logic [RBJ_ATT_W-1:0]  attempts;
  logic [RBJ_TIME_W-1:0] fail_time;
  logic [RBJ_TIME_W-1:0] cur_delay;
  logic                  armed;

  int err_total = 0;
  int awaiting  = 0;

  assign errors  = err_total;
  assign pending = awaiting;

  function automatic logic [RBJ_TIME_W-1:0] scramble32(input logic [RBJ_TIME_W-1:0] v);
    v = v ^ (v >> 16);
    v = v * RBJ_MIX_C1;
    v = v ^ (v >> 15);
    v = v * RBJ_MIX_C2;
    v = v ^ (v >> 16);
    return v;
  endfunction

  function automatic logic [RBJ_TIME_W-1:0] jittered_delay(
    input logic [RBJ_TIME_W-1:0] base,
    input logic [RBJ_PCT_W-1:0]  pct,
    input logic [RBJ_TIME_W-1:0] seed
  );
    logic [RBJ_TIME_W-1:0] span;
    logic [RBJ_TIME_W-1:0] modulus;
    logic [RBJ_TIME_W-1:0] offset;
    logic [RBJ_PROD_W-1:0] upper;
    if (pct == '0 || base == '0) return base;
    span = (base / 32'd100) * {24'd0, pct};
    if (span == '0) return base;
    modulus = span * 32'd2 + 32'd1;
    offset  = scramble32(seed) % modulus;
    // Exact sum first; below zero clamps, above 32 bits wraps.
    upper = {32'd0, base} + {32'd0, offset};
    if (upper < {32'd0, span}) return '0;
    upper = upper - {32'd0, span};
    return upper[RBJ_TIME_W-1:0];
  endfunction

  function automatic timer_status_t apply_event(
    input logic [RBJ_KIND_W-1:0] kind,
    input logic [RBJ_TIME_W-1:0] now
  );
    timer_status_t         res;
    int unsigned           steps;
    int unsigned           slot;
    logic [RBJ_TIME_W-1:0] seed;
    logic [RBJ_TIME_W-1:0] elapsed;
    if (kind == KIND_FAIL) begin
      steps = (step_count > RBJ_MAX_STEPS) ? RBJ_MAX_STEPS : step_count;
      if (steps != 0) begin
        slot = (attempts < steps) ? attempts : steps - 1;
        seed = now ^ ({24'd0, attempts} * RBJ_GOLDEN);
        cur_delay = jittered_delay(step_delay[slot], jitter_pct, seed);
        fail_time = now;
        armed     = 1'b1;
        if (attempts != RBJ_ATT_MAX) attempts = attempts + 1'b1;
      end
    end else if (kind == KIND_CLEAR) begin
      attempts  = '0;
      fail_time = '0;
      cur_delay = '0;
      armed     = 1'b0;
    end
    elapsed           = now - fail_time;
    res.is_ready      = !armed || (elapsed >= cur_delay);
    res.delay_ms      = armed ? cur_delay : '0;
    res.attempt_count = attempts;
    return res;
  endfunction

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    err_total++;
    $display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    timer_status_t want;
    if (!rst_n) begin
      step_count = '0;
      jitter_pct = '0;
      foreach (step_delay[i]) step_delay[i] = '0;
      attempts  = '0;
      fail_time = '0;
      cur_delay = '0;
      armed     = 1'b0;
      status_q.delete();
      awaiting = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_STEP_COUNT)
          step_count = cfg_mon.data[RBJ_CNT_W-1:0];
        else if (cfg_mon.index == REG_JITTER_PCT)
          jitter_pct = cfg_mon.data[RBJ_PCT_W-1:0];
        else if (cfg_mon.index >= REG_STEP_DELAY0 &&
                 cfg_mon.index < REG_STEP_DELAY0 + RBJ_TABLE_SLOTS)
          step_delay[cfg_mon.index - REG_STEP_DELAY0] = cfg_mon.data;
      end
      // The request is queued before the result is taken, so a result that
      // leaves in the same cycle still finds its expectation at the front.
      if (in_mon.valid && in_mon.ready)
        status_q.push_back(apply_event(in_mon.kind, in_mon.now_ms));
      if (out_mon.valid && out_mon.ready) begin
        if (status_q.size() == 0) begin
          report("result with no request outstanding", '0, out_mon.delay_ms);
        end else begin
          want = status_q.pop_front();
          if (out_mon.is_ready !== want.is_ready)
            report("is_ready", want.is_ready, out_mon.is_ready);
          if (out_mon.delay_ms !== want.delay_ms)
            report("delay_ms", want.delay_ms, out_mon.delay_ms);
          if (out_mon.attempt_count !== want.attempt_count)
            report("attempt_count", want.attempt_count, out_mon.attempt_count);
        end
      end
      awaiting = status_q.size();
    end
  end

endmodule

// ===== tb/tb_retry_backoff_jitter_timer_top.sv =====
`timescale 1ns / 1ps

module tb_retry_backoff_jitter_timer_top;
  import rbj_pkg::*;

  // Kind three is not a named operation; the block treats it as a poll.
  localparam logic [RBJ_KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 300;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rbj_in_if  in_ch ();
  rbj_out_if out_ch ();
  rbj_cfg_if cfg_ch ();

  int errors;
  int pending;
  int hold_requests = 0;
  int burst_left;

  logic [RBJ_TIME_W-1:0] clock_ms;
  logic [RBJ_TIME_W-1:0] fail_ms;
  int unsigned           set_count;
  int unsigned           set_pct;
  logic [RBJ_TIME_W-1:0] set_delay [RBJ_TABLE_SLOTS];

  retry_backoff_jitter_timer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  rbj_status_checker status_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .cfg_mon (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("tb_retry_backoff_jitter_timer_top: done, errors");
    $finish;
  end

  // Result side: stall patterns are redrawn at random, and a long
  // hold-off runs whenever the request side asks for one.
  initial begin
    int mode;
    int left;
    int n;
    int holds_done;
    mode = 0;
    left = 0;
    holds_done = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        out_ch.ready = 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 80);
      end
      left--;
      case (mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = 1'($urandom_range(0, 1));
        2: out_ch.ready = ($urandom_range(0, 3) == 0);
        default: out_ch.ready = (left % 3 == 0);
      endcase
    end
  end

  task automatic send_event(input logic [RBJ_KIND_W-1:0] kind, input logic [RBJ_TIME_W-1:0] now);
    in_ch.valid  = 1'b1;
    in_ch.kind   = kind;
    in_ch.now_ms = now;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // Stop offering requests and wait until every result has been taken.
  task automatic settle();
    in_ch.valid = 1'b0;
    burst_left  = 0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [RBJ_CFG_IDX_W-1:0] idx, input logic [RBJ_TIME_W-1:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic load_settings();
    logic [RBJ_CFG_IDX_W-1:0] idx;
    settle();
    // Upper data bits are junk; the block keeps only the field width.
    write_reg(REG_STEP_COUNT, ($urandom() & ~32'h7) | set_count);
    write_reg(REG_JITTER_PCT, ($urandom() & ~32'hFF) | set_pct);
    for (int i = 0; i < RBJ_TABLE_SLOTS; i++)
      write_reg(RBJ_CFG_IDX_W'(REG_STEP_DELAY0 + i), set_delay[i]);
    if ($urandom_range(0, 1)) begin
      idx = RBJ_CFG_IDX_W'(REG_STEP_DELAY0 + RBJ_TABLE_SLOTS + $urandom_range(0, 7));
      write_reg(idx, $urandom());
    end
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [RBJ_TIME_W-1:0] pick_delay();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 200);
      3, 4: return $urandom_range(1000, 100000);
      5: return $urandom();
      default: return $urandom_range(100, 5000);
    endcase
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 6))
      0, 1: return 0;
      2: return 1;
      3: return 100;
      4: return 255;
      5: return $urandom_range(1, 20);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic random_event(input bit fail_heavy);
    int unsigned           r;
    logic [RBJ_KIND_W-1:0] kind;
    logic [RBJ_TIME_W-1:0] now;
    r = $urandom_range(0, 99);
    if (fail_heavy)
      kind = (r < 85) ? KIND_FAIL : KIND_POLL;
    else if (r < 30)
      kind = KIND_FAIL;
    else if (r < 80)
      kind = KIND_POLL;
    else if (r < 90)
      kind = KIND_CLEAR;
    else
      kind = KIND_SPARE;
    // Event times are often aimed at the edge of a base delay after the last failure.
    case ($urandom_range(0, 9))
      0: now = $urandom();
      1, 2, 3: now = fail_ms + set_delay[$urandom_range(0, RBJ_TABLE_SLOTS - 1)]
                     + $urandom_range(0, 4) - 2;
      default: now = clock_ms + $urandom_range(0, 300);
    endcase
    clock_ms = now;
    if (kind == KIND_FAIL) fail_ms = now;
    send_event(kind, now);
  endtask

  initial begin
    int phase;
    int k;
    int items;
    int waited;
    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_POLL;
    in_ch.now_ms = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_STEP_COUNT;
    cfg_ch.data  = '0;
    burst_left = 0;
    clock_ms   = '0;
    fail_ms    = '0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // With no steps configured a failure must leave the timer disarmed.
    send_event(KIND_FAIL, 32'd100);
    send_event(KIND_POLL, 32'd0);
    send_event(KIND_SPARE, 32'hFFFF_FFFF);

    set_count = 3;
    set_pct   = 0;
    set_delay = '{32'd1000, 32'd0, 32'hFFFF_FFFF, 32'd7, 32'd8, 32'd9};
    load_settings();
    send_event(KIND_FAIL, 32'hFFFF_FF00);
    send_event(KIND_POLL, 32'hFFFF_FF00 + 32'd999);
    send_event(KIND_POLL, 32'hFFFF_FF00 + 32'd1000);
    send_event(KIND_FAIL, 32'd5);
    send_event(KIND_FAIL, 32'd10);
    send_event(KIND_POLL, 32'd9);
    send_event(KIND_FAIL, 32'd20);
    send_event(KIND_SPARE, 32'd21);
    send_event(KIND_CLEAR, 32'd7);
    send_event(KIND_POLL, 32'd8);

    // Step count above the table size, full jitter, and a delay just below
    // one percent granularity so the span comes out zero.
    set_count = 7;
    set_pct   = 255;
    set_delay = '{32'hFFFF_FFFF, 32'd100, 32'd99, 32'hFFFF_FF00, 32'd50000, 32'd1};
    load_settings();
    send_event(KIND_FAIL, 32'd0);
    send_event(KIND_FAIL, 32'hFFFF_FFFF);
    send_event(KIND_FAIL, 32'h8000_0000);
    send_event(KIND_FAIL, 32'h7FFF_FFFF);
    send_event(KIND_FAIL, 32'h5555_5555);
    send_event(KIND_FAIL, 32'hAAAA_AAAA);
    send_event(KIND_POLL, 32'hAAAA_AAAB);
    send_event(KIND_FAIL, 32'h1234_5678);
    send_event(KIND_CLEAR, 32'd0);

    for (phase = 0; phase < 7; phase++) begin
      set_count = $urandom_range(0, 7);
      set_pct   = pick_pct();
      foreach (set_delay[i]) set_delay[i] = pick_delay();
      // One phase runs long chains of failures so the attempt count saturates.
      if (phase == 2) set_count = $urandom_range(1, 7);
      if (phase == 6) begin
        set_count = 1;
        set_pct   = 1;
      end
      load_settings();
      items = (phase == 2) ? 300 : 80;
      for (k = 0; k < items; k++) begin
        if (phase == 3 && k == 20) hold_requests++;
        if (phase == 5 && k == 40) settle();
        random_event(phase == 2);
      end
    end

    in_ch.valid = 1'b0;
    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("tb_retry_backoff_jitter_timer_top: done, clean");
    else
      $display("tb_retry_backoff_jitter_timer_top: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
src/rbj_pkg.sv
src/rbj_if.sv
src/rbj_mul.sv
src/rbj_mod.sv
src/rbj_seq.sv
src/retry_backoff_jitter_timer_top.sv
tb/rbj_status_checker.sv
tb/tb_retry_backoff_jitter_timer_top.sv
